// ===== design/awt_pkg.sv =====
// awt_pkg: shared types and constants of the address watchpoint table
// used by every design file; no dependencies

package awt_pkg;

	localparam int WATCH_ENTRIES_DEF = 16;
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 8;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_CHECK  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_HOLD
	} state_t;

	typedef struct packed {
		mode_t             mode;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] access_size;
	} awt_in_t;

	typedef struct packed {
		logic hit;
		logic watch_active;
		logic add_dropped;
	} awt_out_t;

	// command token walking along the row of cells
	typedef struct packed {
		logic              vld;
		mode_t             mode;
		logic              pass;    // 0 scan, 1 insert
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W:0]   hi;      // addr + access_size, no wrap
		logic              dup;
		logic              free;
		logic              claimed;
		logic              hit;
		logic              active;
	} awt_tok_t;

endpackage

// ===== design/awt_cell.sv =====
// awt_cell: one table slot holding an address and its valid flag
// applies the passing command token and hands it to the next cell; uses awt_pkg

module awt_cell
	import awt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  awt_tok_t tok_in,
	output awt_tok_t tok_out
);

	logic              valid_q;
	logic              vld_q;
	logic [ADDR_W-1:0] addr_q;
	awt_tok_t          tok_q;

	logic     match;
	logic     in_range;
	logic     valid_d;
	logic     wr_en;
	awt_tok_t tok_d;

	assign match    = valid_q && (addr_q == tok_in.addr);
	assign in_range = valid_q && (addr_q >= tok_in.addr) && ({1'b0, addr_q} < tok_in.hi);

	always_comb begin
		tok_d   = tok_in;
		valid_d = valid_q;
		wr_en   = 1'b0;
		if (tok_in.vld) begin
			case (tok_in.mode)
				MODE_ADD: begin
					if (!tok_in.pass) begin
						tok_d.dup    = tok_in.dup | match;
						tok_d.free   = tok_in.free | !valid_q;
						tok_d.active = tok_in.active | valid_q;
					end else if (!tok_in.claimed && !valid_q) begin
						wr_en         = 1'b1;
						valid_d       = 1'b1;
						tok_d.claimed = 1'b1;
					end
				end
				MODE_REMOVE: begin
					if (match)
						valid_d = 1'b0;
					tok_d.active = tok_in.active | (valid_q && !match);
				end
				MODE_CLEAR: begin
					valid_d = 1'b0;
				end
				MODE_CHECK: begin
					tok_d.hit    = tok_in.hit | in_range;
					tok_d.active = tok_in.active | valid_q;
				end
				default: begin
					tok_d = tok_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			valid_q <= valid_d;
			vld_q   <= tok_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			addr_q <= tok_in.addr;
		tok_q <= tok_d;
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

endmodule

// ===== design/address_watchpoint_table_top.sv =====
// address_watchpoint_table_top: watched address table built as a row of slot cells
// with command sequencer and output register; uses awt_pkg and awt_cell

// Every command token walks the row of WATCH_ENTRIES cells, one cell per cycle, and
// its result is registered as it leaves the last cell. An add that stores an address
// makes a second walk to claim the lowest free slot; a remove, clear, check or
// non-storing add makes one walk. One command is in the row at a time; the next is
// taken once the result of the last one is in the output register.
// A result may wait in the output register while the next command runs; if the
// output register is still full when a result finishes, that result is parked and
// no new transfer is taken until it moves on. The table is empty after reset.

module address_watchpoint_table_top
	import awt_pkg::*;
#(
	parameter int WATCH_ENTRIES = WATCH_ENTRIES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  awt_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output awt_out_t out_data
);

	state_t   state_q, state_d;
	awt_tok_t tok [WATCH_ENTRIES+1];
	awt_tok_t exit_tok;
	awt_tok_t entry_tok;

	awt_out_t res_q, hold_q, fin_res;
	logic     out_valid_q;
	logic     slot_free;
	logic     finish;
	logic     load_fin;
	logic     load_hold;
	logic     save_hold;

	assign exit_tok  = tok[WATCH_ENTRIES];
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_BUSY;
			end
			ST_BUSY: begin
				if (finish)
					state_d = slot_free ? ST_IDLE : ST_HOLD;
			end
			ST_HOLD: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		finish    = 1'b0;
		load_fin  = 1'b0;
		load_hold = 1'b0;
		save_hold = 1'b0;
		entry_tok = '0;
		fin_res.hit          = exit_tok.hit;
		fin_res.watch_active = exit_tok.active;
		fin_res.add_dropped  = (exit_tok.mode == MODE_ADD) && !exit_tok.pass &&
			!exit_tok.dup && !exit_tok.free;
		case (state_q)
			ST_IDLE: begin
				entry_tok.vld  = in_valid;
				entry_tok.mode = in_data.mode;
				entry_tok.addr = in_data.addr;
				entry_tok.hi   = {1'b0, in_data.addr} +
					{{(ADDR_W+1-SIZE_W){1'b0}}, in_data.access_size};
			end
			ST_BUSY: begin
				if (exit_tok.vld) begin
					if ((exit_tok.mode == MODE_ADD) && !exit_tok.pass &&
						!exit_tok.dup && exit_tok.free) begin
						entry_tok        = exit_tok;
						entry_tok.pass   = 1'b1;
						entry_tok.active = 1'b1;
					end else begin
						finish    = 1'b1;
						load_fin  = slot_free;
						save_hold = !slot_free;
					end
				end
			end
			ST_HOLD: begin
				load_hold = slot_free;
			end
			default: entry_tok = '0;
		endcase
	end

	assign tok[0] = entry_tok;

	for (genvar i = 0; i < WATCH_ENTRIES; i++) begin : g_cell
		awt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_fin || load_hold)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_fin)
			res_q <= fin_res;
		else if (load_hold)
			res_q <= hold_q;
		if (save_hold)
			hold_q <= fin_res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

endmodule

// ===== design/awt_checker.sv =====
// awt_checker: port-level checks of the address watchpoint table
// bound to address_watchpoint_table_top; uses awt_pkg

module awt_checker
	import awt_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input awt_in_t  in_data,
	input logic     out_valid,
	input logic     out_ready,
	input awt_out_t out_data
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a full table cannot be empty
	a_drop_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.add_dropped |-> out_data.watch_active)
		else $error("dropped add with empty table");

	// a hit needs a watched address
	a_hit_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.watch_active)
		else $error("hit with empty table");

	// hit and dropped come from different commands
	a_hit_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.add_dropped))
		else $error("hit and dropped together");

	// no new transfer taken the cycle after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken back to back");

endmodule

bind address_watchpoint_table_top awt_checker u_awt_checker (.*);
